### src/assert_macros.svh
// Assertion macros shared by the scan response tracker RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SST_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sst assertion failed");
`define SST_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sst assertion failed");
`else
`define SST_ASSERT_IMP(name, clk, rst, ante, cons)
`define SST_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### src/sst_pkg.sv
// Shared constants, codes and types of the scan response tracker.
// No dependencies; used by the parser and the top level.
package sst_pkg;

   localparam int PORT_COUNT = 65536;
   localparam int PORT_AW    = (PORT_COUNT > 2) ? $clog2(PORT_COUNT) : 1;

   localparam logic [1:0] PS_UNKNOWN  = 2'd0;
   localparam logic [1:0] PS_OPEN     = 2'd1;
   localparam logic [1:0] PS_CLOSED   = 2'd2;
   localparam logic [1:0] PS_FILTERED = 2'd3;

   localparam logic [1:0] VERDICT_IGNORED = 2'd0;
   localparam logic [1:0] VERDICT_RST     = 2'd1;
   localparam logic [1:0] VERDICT_OPEN    = 2'd2;
   localparam logic [1:0] VERDICT_READ    = 2'd3;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_RST_BIT = 2;
   localparam int FLAG_ACK_BIT = 4;

   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [15:0] OUR_PORT_RESET = 16'd60000;
   localparam logic [6:0]  POS_MAX        = 7'd127;

   localparam logic [1:0] REG_OUR_ADDRESS    = 2'd0;
   localparam logic [1:0] REG_TARGET_ADDRESS = 2'd1;
   localparam logic [1:0] REG_OUR_PORT       = 2'd2;

   typedef struct packed {
      logic        accept;
      logic        rst;
      logic        syn_ack;
      logic [15:0] source_port;
      logic [31:0] ack_number;
   } pkt_info_type;

endpackage

### src/sst_req_if.sv
// Request channel of the scan response tracker: packet bytes and reads.
// Stand-alone valid/ready interface; no package dependency.
interface sst_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [15:0] query_port;

   modport source (output valid, command, data_byte, last_byte, query_port, input ready);
   modport sink (input valid, command, data_byte, last_byte, query_port, output ready);
endinterface

### src/sst_rsp_if.sv
// Response channel of the scan response tracker: verdicts and port states.
// Stand-alone valid/ready interface; no package dependency.
interface sst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [15:0] remote_port;
   logic [31:0] reset_sequence;
   logic [1:0]  port_state;

   modport source (output valid, verdict, remote_port, reset_sequence, port_state,
                   input ready);
   modport sink (input valid, verdict, remote_port, reset_sequence, port_state,
                 output ready);
endinterface

### src/sst_parser.sv
// Byte-serial IPv4/TCP header parser; judges each packet on its last byte.
// Depends on sst_pkg for constants and the packet info struct.
module sst_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_strobe,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic [31:0]          our_address,
   input  logic [31:0]          target_address,
   input  logic [15:0]          our_port,
   output sst_pkg::pkt_info_type pkt_info
);

   logic [6:0]  byte_position_ff, byte_position_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic        protocol_ok_ff, protocol_ok_in;
   logic        address_ok_ff, address_ok_in;
   logic [15:0] source_port_ff, source_port_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic [31:0] ack_number_ff, ack_number_in;
   logic [7:0]  flags_ff, flags_in;

   logic [6:0]  pos;
   logic [6:0]  offset;
   logic [6:0]  tcp_index;
   logic [7:0]  want_target;
   logic [7:0]  want_ours;
   logic [7:0]  length;
   logic [7:0]  min_length;

   always_comb begin
      pos = byte_position_ff;
      header_words_in = (pos == 7'd0) ? data_byte[3:0] : header_words_ff;
      offset = {1'b0, header_words_in, 2'b00};
      tcp_index = pos - offset;

      unique case (pos[1:0])
         2'd0: begin
            want_target = target_address[31:24];
            want_ours   = our_address[31:24];
         end
         2'd1: begin
            want_target = target_address[23:16];
            want_ours   = our_address[23:16];
         end
         2'd2: begin
            want_target = target_address[15:8];
            want_ours   = our_address[15:8];
         end
         default: begin
            want_target = target_address[7:0];
            want_ours   = our_address[7:0];
         end
      endcase

      protocol_ok_in = protocol_ok_ff;
      address_ok_in  = address_ok_ff;
      if (pos == 7'd0) begin
         protocol_ok_in = 1'b0;
         address_ok_in  = 1'b1;
      end else if (pos == 7'd9) begin
         protocol_ok_in = (data_byte == sst_pkg::PROTO_TCP);
      end else if (pos >= 7'd12 && pos <= 7'd15) begin
         if (data_byte != want_target) address_ok_in = 1'b0;
      end else if (pos >= 7'd16 && pos <= 7'd19) begin
         if (data_byte != want_ours) address_ok_in = 1'b0;
      end

      source_port_in = source_port_ff;
      dest_port_in   = dest_port_ff;
      ack_number_in  = ack_number_ff;
      flags_in       = flags_ff;
      if (pos >= offset) begin
         if (tcp_index < 7'd2) begin
            source_port_in = {source_port_ff[7:0], data_byte};
         end else if (tcp_index < 7'd4) begin
            dest_port_in = {dest_port_ff[7:0], data_byte};
         end else if (tcp_index >= 7'd8 && tcp_index < 7'd12) begin
            ack_number_in = {ack_number_ff[23:0], data_byte};
         end else if (tcp_index == 7'd13) begin
            flags_in = data_byte;
         end
      end

      if (last_byte) begin
         byte_position_in = 7'd0;
      end else if (pos == sst_pkg::POS_MAX) begin
         byte_position_in = pos;
      end else begin
         byte_position_in = pos + 7'd1;
      end

      length     = {1'b0, pos} + 8'd1;
      min_length = {2'b00, header_words_in, 2'b00} + 8'd20;

      pkt_info.accept = (header_words_in >= 4'd5) && (length >= min_length) &&
                        protocol_ok_in && address_ok_in && (dest_port_in == our_port);
      pkt_info.rst = flags_in[sst_pkg::FLAG_RST_BIT];
      pkt_info.syn_ack = flags_in[sst_pkg::FLAG_SYN_BIT] & flags_in[sst_pkg::FLAG_ACK_BIT];
      pkt_info.source_port = source_port_in;
      pkt_info.ack_number = ack_number_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         header_words_ff  <= '0;
         protocol_ok_ff   <= 1'b0;
         address_ok_ff    <= 1'b0;
         source_port_ff   <= '0;
         dest_port_ff     <= '0;
         ack_number_ff    <= '0;
         flags_ff         <= '0;
      end else if (byte_strobe) begin
         byte_position_ff <= byte_position_in;
         header_words_ff  <= header_words_in;
         protocol_ok_ff   <= protocol_ok_in;
         address_ok_ff    <= address_ok_in;
         source_port_ff   <= source_port_in;
         dest_port_ff     <= dest_port_in;
         ack_number_ff    <= ack_number_in;
         flags_ff         <= flags_in;
      end
   end

endmodule

### src/syn_scan_response_tracker.sv
// Top level of the scan response tracker: config registers, port state table, responses.
// Depends on sst_pkg, sst_req_if, sst_rsp_if, sst_parser and assert_macros.svh.
//
// Usage:
//   req channel: command 0 carries one packet byte (data_byte, last_byte),
//   starting at the IP header; command 1 reads query_port's state and turns
//   unknown into filtered. rsp channel: one response per last byte and per
//   read, none for other bytes. Verdict 0 ignored, 1 RST seen, 2 SYN-ACK seen
//   (reset_sequence holds its ACK number), 3 state read.
//   Throughput: one request per cycle sustained while rsp.ready is high. The
//   port table is a single-port-write, registered-read memory; a read or a
//   last byte reads it on accept, the next stage modifies and writes back,
//   forwarding the last write to a back-to-back request for the same port.
//   A request is registered in the memory stage, then its response in the output register.
//   Reset: a clearing pass writes unknown to all PORT_COUNT (65536) table
//   entries, one per cycle; req.ready stays low meanwhile, while
//   configuration writes are taken as usual.
//   Stall: with rsp.ready low, one response waits in the output register and
//   one more request is taken into the memory stage; then req.ready drops.
//   Configuration: APB, 32-bit registers at byte addresses 0, 4 and 8.
`include "assert_macros.svh"

module syn_scan_response_tracker (
   input  logic        clock,
   input  logic        reset,
   sst_req_if.sink     req,
   sst_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] our_address_ff;
   logic [31:0] target_address_ff;
   logic [15:0] our_port_ff;
   logic        csr_write;

   logic        clear_busy_ff;
   logic [sst_pkg::PORT_AW-1:0] clear_count_ff;

   logic        req_accept;
   logic        byte_strobe;
   logic        issue;
   sst_pkg::pkt_info_type pkt_info;

   logic [1:0]  state_mem [sst_pkg::PORT_COUNT];
   logic [1:0]  rd_data_ff;
   logic [sst_pkg::PORT_AW-1:0] rd_addr;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff, s1_op_in;
   logic [15:0] s1_port_ff, s1_port_in;
   logic [31:0] s1_ack_ff, s1_ack_in;
   logic        s1_advance;
   logic        s1_in_table;
   logic [sst_pkg::PORT_AW-1:0] s1_addr;
   logic [1:0]  cur_state;
   logic [1:0]  new_state;
   logic        wr_en;
   logic [1:0]  out_state;
   logic [31:0] out_sequence;
   logic [15:0] out_port;

   logic        fwd_valid_ff;
   logic [sst_pkg::PORT_AW-1:0] fwd_addr_ff;
   logic [1:0]  fwd_data_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_verdict_ff;
   logic [15:0] rsp_port_ff;
   logic [31:0] rsp_sequence_ff;
   logic [1:0]  rsp_state_ff;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         our_address_ff    <= '0;
         target_address_ff <= '0;
         our_port_ff       <= sst_pkg::OUR_PORT_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            sst_pkg::REG_OUR_ADDRESS:    our_address_ff <= pwdata;
            sst_pkg::REG_TARGET_ADDRESS: target_address_ff <= pwdata;
            sst_pkg::REG_OUR_PORT:       our_port_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         sst_pkg::REG_OUR_ADDRESS:    prdata = our_address_ff;
         sst_pkg::REG_TARGET_ADDRESS: prdata = target_address_ff;
         sst_pkg::REG_OUR_PORT:       prdata = {16'd0, our_port_ff};
         default:                     prdata = '0;
      endcase
   end

   // table clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff  <= 1'b1;
         clear_count_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_count_ff <= clear_count_ff + 1'b1;
         if (clear_count_ff == sst_pkg::PORT_AW'(sst_pkg::PORT_COUNT - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // request side
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !clear_busy_ff && (!s1_valid_ff || s1_advance);
   assign req_accept  = req.valid && req.ready;
   assign byte_strobe = req_accept && (req.command == sst_pkg::CMD_BYTE);
   assign issue       = req_accept && ((req.command == sst_pkg::CMD_READ) || req.last_byte);

   sst_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .byte_strobe    (byte_strobe),
      .data_byte      (req.data_byte),
      .last_byte      (req.last_byte),
      .our_address    (our_address_ff),
      .target_address (target_address_ff),
      .our_port       (our_port_ff),
      .pkt_info       (pkt_info)
   );

   always_comb begin
      s1_port_in = pkt_info.source_port;
      s1_ack_in  = pkt_info.ack_number;
      if (req.command == sst_pkg::CMD_READ) begin
         s1_op_in   = sst_pkg::VERDICT_READ;
         s1_port_in = req.query_port;
      end else if (!pkt_info.accept) begin
         s1_op_in = sst_pkg::VERDICT_IGNORED;
      end else if (pkt_info.rst) begin
         s1_op_in = sst_pkg::VERDICT_RST;
      end else if (pkt_info.syn_ack) begin
         s1_op_in = sst_pkg::VERDICT_OPEN;
      end else begin
         s1_op_in = sst_pkg::VERDICT_IGNORED;
      end
      rd_addr = s1_port_in[sst_pkg::PORT_AW-1:0];

      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_op_ff   <= s1_op_in;
         s1_port_ff <= s1_port_in;
         s1_ack_ff  <= s1_ack_in;
      end
   end

   // memory stage: modify and write back
   assign s1_addr     = s1_port_ff[sst_pkg::PORT_AW-1:0];
   assign s1_in_table = {1'b0, s1_port_ff} < 17'(sst_pkg::PORT_COUNT);
   assign cur_state   = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : rd_data_ff;

   always_comb begin
      new_state    = cur_state;
      out_state    = sst_pkg::PS_UNKNOWN;
      out_sequence = '0;
      out_port     = s1_port_ff;
      wr_en        = 1'b0;
      unique case (s1_op_ff)
         sst_pkg::VERDICT_READ: begin
            if (cur_state == sst_pkg::PS_UNKNOWN) new_state = sst_pkg::PS_FILTERED;
            out_state = s1_in_table ? new_state : sst_pkg::PS_FILTERED;
            wr_en     = s1_in_table;
         end
         sst_pkg::VERDICT_RST: begin
            if (cur_state == sst_pkg::PS_UNKNOWN) new_state = sst_pkg::PS_CLOSED;
            out_state = s1_in_table ? new_state : sst_pkg::PS_UNKNOWN;
            wr_en     = s1_in_table;
         end
         sst_pkg::VERDICT_OPEN: begin
            new_state    = sst_pkg::PS_OPEN;
            out_state    = s1_in_table ? sst_pkg::PS_OPEN : sst_pkg::PS_UNKNOWN;
            out_sequence = s1_ack_ff;
            wr_en        = s1_in_table;
         end
         default: begin
            out_port = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         state_mem[clear_count_ff] <= sst_pkg::PS_UNKNOWN;
      end else if (s1_advance && wr_en) begin
         state_mem[s1_addr] <= new_state;
      end
      if (issue) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_advance && wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_state;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_verdict_ff  <= s1_op_ff;
         rsp_port_ff     <= out_port;
         rsp_sequence_ff <= out_sequence;
         rsp_state_ff    <= out_state;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.verdict        = rsp_verdict_ff;
   assign rsp.remote_port    = rsp_port_ff;
   assign rsp.reset_sequence = rsp_sequence_ff;
   assign rsp.port_state     = rsp_state_ff;

   `SST_ASSERT_IMP(a_no_accept_in_clear, clock, reset, clear_busy_ff, !req_accept && !s1_valid_ff)
   `SST_ASSERT_IMP(a_read_never_unknown, clock, reset,
                   rsp_valid_ff && (rsp_verdict_ff == sst_pkg::VERDICT_READ),
                   rsp_state_ff != sst_pkg::PS_UNKNOWN)
   `SST_ASSERT_NXT(a_open_forwarded, clock, reset,
                   s1_advance && wr_en && (s1_op_ff == sst_pkg::VERDICT_OPEN),
                   fwd_valid_ff && (fwd_data_ff == sst_pkg::PS_OPEN))
   `SST_ASSERT_IMP(a_issue_needs_room, clock, reset, issue, !s1_valid_ff || s1_advance)

endmodule
